/* rtl/cdps_pkg.sv */
// Package for the continuous-DP spotting block: payload structs, column word,
// action and register codes, reset constants. No dependencies.
package cdps_pkg;

	// item actions
	localparam logic [1:0] ACT_LOAD    = 2'd0;
	localparam logic [1:0] ACT_STREAM  = 2'd1;
	localparam logic [1:0] ACT_RESTART = 2'd2;
	localparam logic [1:0] ACT_UNUSED  = 2'd3;

	// configuration register indexes
	localparam logic [1:0] REG_LIMIT  = 2'd0;
	localparam logic [1:0] REG_THRESH = 2'd1;

	localparam logic [15:0] LIMIT_RESET  = 16'd20000;
	localparam logic [15:0] THRESH_RESET = 16'd0;

	// start frame tag with bit 16 set: no path
	localparam logic [16:0] START_NONE = 17'h10000;

	typedef struct packed {
		logic [1:0] action;
		logic [7:0] sample;
		logic [6:0] ref_index;
		logic [6:0] block_height;
	} cdps_item_t;

	typedef struct packed {
		logic [15:0] frame_index;
		logic [15:0] end_distance;
		logic [15:0] start_frame;
		logic        path_found;
		logic        below_threshold;
	} cdps_result_t;

	// one row of the lattice state
	typedef struct packed {
		logic [15:0] ldist;
		logic [15:0] acc;
		logic [15:0] acc2;
		logic [16:0] start;
		logic [16:0] start2;
	} cdps_col_t;

	// last-row outcome of one column sweep
	typedef struct packed {
		logic        valid;
		logic [15:0] end_distance;
		logic [16:0] start;
	} cdps_fin_t;

endpackage

/* rtl/cdps_row_pipe.sv */
// Row update pipeline: local distance, three weighted paths, path selection.
// Depends on cdps_pkg; fed by the column and reference memories of the top level.
module cdps_row_pipe import cdps_pkg::*; #(
	parameter int unsigned REF_LEN = 80
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       rd_en,
	input  logic [$clog2(REF_LEN)-1:0] rd_row,
	input  logic [7:0]                 ref_q,
	input  cdps_col_t                  col_q,
	input  logic [7:0]                 sample,
	input  logic [6:0]                 block_height,
	input  logic [15:0]                limit,
	input  logic [15:0]                frame,
	output logic                       wr_en,
	output logic [$clog2(REF_LEN)-1:0] wr_row,
	output cdps_col_t                  wr_word,
	output cdps_fin_t                  fin
);

	localparam int unsigned RW = $clog2(REF_LEN);
	localparam logic [RW-1:0] LAST_ROW = RW'(REF_LEN - 1);

	function automatic logic [15:0] sat19(input logic [18:0] v, input logic [15:0] lim);
		sat19 = (v >= {3'b000, lim}) ? lim : v[15:0];
	endfunction

	// s1: memory data valid
	logic          v_s1;
	logic [RW-1:0] row_s1;
	logic [7:0]    absd;
	logic          blocked;
	logic [15:0]   d_raw;
	logic [15:0]   d_new;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else begin
			v_s1 <= rd_en;
		end
	end

	always_ff @(posedge clk) begin
		row_s1 <= rd_row;
	end

	always_comb begin
		absd    = (ref_q > sample) ? (ref_q - sample) : (sample - ref_q);
		blocked = (block_height != 7'd0) && (32'(row_s1) <= 32'(block_height));
		d_raw   = blocked ? limit : {8'd0, absd};
		d_new   = (d_raw >= limit) ? limit : d_raw;
	end

	// s2: candidate sums; keeps old entries of rows i-1 and i-2
	logic          v_s2;
	logic [RW-1:0] row_s2;
	logic [15:0]   d_s2;
	logic [15:0]   dm1_s2;
	cdps_col_t     e_s2;
	cdps_col_t     em1_s2;
	cdps_col_t     em2_s2;
	logic [18:0]   d3;
	logic [18:0]   dm3;
	logic [18:0]   sum1;
	logic [18:0]   sum2;
	logic [18:0]   sum3;
	logic [15:0]   c1;
	logic [15:0]   c2;
	logic [15:0]   c3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else begin
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (v_s1) begin
			row_s2 <= row_s1;
			d_s2   <= d_new;
			dm1_s2 <= d_s2;
			e_s2   <= col_q;
			em1_s2 <= e_s2;
			em2_s2 <= em1_s2;
		end
	end

	always_comb begin
		d3   = 19'(d_s2) + (19'(d_s2) << 1);
		dm3  = 19'(dm1_s2) + (19'(dm1_s2) << 1);
		sum1 = 19'(em1_s2.acc2) + (19'(e_s2.ldist) << 1) + 19'(d_s2);
		sum2 = 19'(em1_s2.acc) + d3;
		sum3 = 19'(em2_s2.acc) + dm3 + d3;
		// row 0 restarts at 3*d
		c1   = (row_s2 == '0) ? sat19(d3, limit) : sat19(sum1, limit);
		c2   = sat19(sum2, limit);
		c3   = (row_s2 >= RW'(2)) ? sat19(sum3, limit) : limit;
	end

	// s3: select and write back
	logic          v_s3;
	logic [RW-1:0] row_s3;
	logic [15:0]   c1_s3;
	logic [15:0]   c2_s3;
	logic [15:0]   c3_s3;
	logic [16:0]   st1_s3;
	logic [16:0]   st2_s3;
	logic [16:0]   st3_s3;
	logic [15:0]   d_s3;
	logic [15:0]   acc_old_s3;
	logic [16:0]   st_old_s3;
	logic [15:0]   new_acc;
	logic [16:0]   new_start;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
		end else begin
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (v_s2) begin
			row_s3     <= row_s2;
			c1_s3      <= c1;
			c2_s3      <= c2;
			c3_s3      <= c3;
			st1_s3     <= em1_s2.start2;
			st2_s3     <= em1_s2.start;
			st3_s3     <= em2_s2.start;
			d_s3       <= d_s2;
			acc_old_s3 <= e_s2.acc;
			st_old_s3  <= e_s2.start;
		end
	end

	// ties go to path 1, then 2, then 3
	always_comb begin
		if (row_s3 == '0) begin
			new_acc   = c1_s3;
			new_start = {1'b0, frame};
		end else if (c1_s3 <= c2_s3 && c1_s3 <= c3_s3 && c1_s3 < limit) begin
			new_acc   = c1_s3;
			new_start = st1_s3;
		end else if (c2_s3 <= c1_s3 && c2_s3 <= c3_s3 && c2_s3 < limit) begin
			new_acc   = c2_s3;
			new_start = st2_s3;
		end else if (c3_s3 <= c1_s3 && c3_s3 <= c2_s3 && c3_s3 < limit) begin
			new_acc   = c3_s3;
			new_start = st3_s3;
		end else begin
			new_acc   = limit;
			new_start = START_NONE;
		end
	end

	always_comb begin
		wr_en          = v_s3;
		wr_row         = row_s3;
		wr_word.ldist  = d_s3;
		wr_word.acc    = new_acc;
		wr_word.acc2   = acc_old_s3;
		wr_word.start  = new_start;
		wr_word.start2 = st_old_s3;
		fin.valid        = v_s3 && (row_s3 == LAST_ROW);
		fin.end_distance = new_acc;
		fin.start        = new_start;
	end

endmodule

/* rtl/continuous_dp_spotting.sv */
// Top level: configuration, sequencer, reference and column memories, output.
// Depends on cdps_pkg and cdps_row_pipe. Stream item: REF_LEN row reads, the
// 3-stage row pipe, then the pending and output registers lead to the result; the next
// item is taken once the sequencer is idle and no result is pending. Restart: a
// clearing pass over all REF_LEN rows. Reset: asynchronous; control clears at once, then
// a clearing pass runs with items stalled; configuration writes are taken throughout.
module continuous_dp_spotting import cdps_pkg::*; #(
	parameter int unsigned REF_LEN = 80
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         item_valid,
	output logic         item_stall,
	input  cdps_item_t   item,
	output logic         result_valid,
	input  logic         result_stall,
	output cdps_result_t result,
	input  logic         cfg_valid,
	output logic         cfg_ready,
	input  logic [1:0]   cfg_index,
	input  logic [15:0]  cfg_data
);

	localparam int unsigned RW = $clog2(REF_LEN);
	localparam logic [RW-1:0] LAST_ROW = RW'(REF_LEN - 1);

	typedef enum logic [3:0] {
		ST_IDLE  = 4'b0001,
		ST_SWEEP = 4'b0010,
		ST_DRAIN = 4'b0100,
		ST_CLEAR = 4'b1000
	} state_t;

	state_t        state_q;
	logic [RW-1:0] row_q;          // sweep read address / clearing address
	logic [15:0]   limit_q;
	logic [15:0]   thresh_q;
	logic [15:0]   clear_lim_q;    // limit in force when the clear was started
	logic [15:0]   frame_q;
	logic [7:0]    sample_q;
	logic [6:0]    bh_q;
	cdps_result_t  res_q;
	logic          res_pend_q;
	cdps_result_t  out_q;
	logic          out_valid_q;

	logic          item_acc;
	logic          ref_we;
	logic          rd_en;
	logic [7:0]    ref_rdata;
	cdps_col_t     col_rdata;
	logic          pipe_we;
	logic [RW-1:0] pipe_row;
	cdps_col_t     pipe_word;
	cdps_fin_t     fin;
	logic          clr_we;
	logic          col_we;
	logic [RW-1:0] col_wa;
	cdps_col_t     col_wd;
	cdps_col_t     clear_word;
	logic          out_move;
	logic          found;

	// one transaction in flight; a waiting result blocks the next one
	assign item_stall = (state_q != ST_IDLE) || res_pend_q;
	assign item_acc   = item_valid && !item_stall;
	assign cfg_ready  = 1'b1;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			limit_q  <= LIMIT_RESET;
			thresh_q <= THRESH_RESET;
		end else if (cfg_valid) begin
			case (cfg_index)
				REG_LIMIT:  limit_q  <= cfg_data;
				REG_THRESH: thresh_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			row_q       <= '0;
			clear_lim_q <= LIMIT_RESET;
			frame_q     <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (item_acc) begin
						case (item.action)
							ACT_STREAM: begin
								state_q <= ST_SWEEP;
								row_q   <= '0;
							end
							ACT_RESTART: begin
								state_q     <= ST_CLEAR;
								row_q       <= '0;
								clear_lim_q <= limit_q;
								frame_q     <= '0;
							end
							default: ;
						endcase
					end
				end
				ST_SWEEP: begin
					row_q <= row_q + RW'(1);
					if (row_q == LAST_ROW) begin
						state_q <= ST_DRAIN;
					end
				end
				ST_DRAIN: begin
					// last row leaves the pipe: column done
					if (fin.valid) begin
						state_q <= ST_IDLE;
						frame_q <= frame_q + 16'd1;
					end
				end
				ST_CLEAR: begin
					row_q <= row_q + RW'(1);
					if (row_q == LAST_ROW) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// stream sample and block height held for the sweep
	always_ff @(posedge clk) begin
		if (item_acc) begin
			sample_q <= item.sample;
			bh_q     <= item.block_height;
		end
	end

	// reference memory, no reset
	logic [7:0] ref_mem [REF_LEN];

	assign ref_we = item_acc && (item.action == ACT_LOAD) && (32'(item.ref_index) < REF_LEN);
	assign rd_en  = (state_q == ST_SWEEP);

	always_ff @(posedge clk) begin
		if (ref_we) begin
			ref_mem[RW'(item.ref_index)] <= item.sample;
		end
		if (rd_en) begin
			ref_rdata <= ref_mem[row_q];
		end
	end

	// column memory: read ahead by the sweep, written back from the last pipe
	// stage three rows behind, so read and write never hit the same row
	cdps_col_t col_mem [REF_LEN];

	always_comb begin
		clear_word.ldist  = '0;
		clear_word.acc    = clear_lim_q;
		clear_word.acc2   = clear_lim_q;
		clear_word.start  = START_NONE;
		clear_word.start2 = START_NONE;
	end

	assign clr_we = (state_q == ST_CLEAR);
	assign col_we = clr_we || pipe_we;
	assign col_wa = clr_we ? row_q : pipe_row;
	assign col_wd = clr_we ? clear_word : pipe_word;

	always_ff @(posedge clk) begin
		if (col_we) begin
			col_mem[col_wa] <= col_wd;
		end
		if (rd_en) begin
			col_rdata <= col_mem[row_q];
		end
	end

	cdps_row_pipe #(
		.REF_LEN(REF_LEN)
	) u_pipe (
		.clk         (clk),
		.arst_n      (arst_n),
		.rd_en       (rd_en),
		.rd_row      (row_q),
		.ref_q       (ref_rdata),
		.col_q       (col_rdata),
		.sample      (sample_q),
		.block_height(bh_q),
		.limit       (limit_q),
		.frame       (frame_q),
		.wr_en       (pipe_we),
		.wr_row      (pipe_row),
		.wr_word     (pipe_word),
		.fin         (fin)
	);

	// result formation: pending register, then output register
	assign found    = (fin.end_distance < limit_q) && !fin.start[16];
	assign out_move = res_pend_q && (!out_valid_q || !result_stall);

	always_ff @(posedge clk) begin
		if (fin.valid) begin
			res_q.frame_index     <= frame_q;
			res_q.end_distance    <= fin.end_distance;
			res_q.start_frame     <= found ? fin.start[15:0] : 16'd0;
			res_q.path_found      <= found;
			res_q.below_threshold <= found && (fin.end_distance < thresh_q);
		end
		if (out_move) begin
			out_q <= res_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_pend_q  <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (fin.valid) begin
				res_pend_q <= 1'b1;
			end else if (out_move) begin
				res_pend_q <= 1'b0;
			end
			if (out_move) begin
				out_valid_q <= 1'b1;
			end else if (!result_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign result_valid = out_valid_q;
	assign result       = out_q;

	// pipe write-back only during a sweep, never during a clearing pass
	a_wb_in_sweep: assert property (@(posedge clk) disable iff (!arst_n)
		pipe_we |-> (state_q == ST_SWEEP || state_q == ST_DRAIN))
		else $error("column write-back outside a sweep");

	// column end seen only while draining
	a_fin_drain: assert property (@(posedge clk) disable iff (!arst_n)
		fin.valid |-> state_q == ST_DRAIN)
		else $error("column end outside drain");

	// a new result never overwrites one still pending
	a_no_overrun: assert property (@(posedge clk) disable iff (!arst_n)
		fin.valid |-> !res_pend_q)
		else $error("pending result overwritten");

	// no path: start frame zero and no match
	a_no_path: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && !result.path_found) |->
			(result.start_frame == 16'd0 && !result.below_threshold))
		else $error("result fields inconsistent without a path");

endmodule

/* bench/continuous_dp_spotting_tb.sv */
`timescale 1ns / 1ps
// Self-checking bench for continuous_dp_spotting: drives load, stream and restart
// transactions and register writes, predicts every spotting result. Uses cdps_pkg.
module continuous_dp_spotting_tb;
	import cdps_pkg::*;

	localparam int unsigned REF_LEN     = 80;
	// margin that covers a restart clearing pass or any other transaction that
	// is still in flight with no result
	localparam int unsigned SETTLE      = REF_LEN + 20;
	// run-length cap, set well above the slowest legal run
	localparam longint unsigned CYCLE_LIMIT = 3_000_000;
	localparam int unsigned HOLD_OFF    = 2500;
	localparam int unsigned PHASE_ITEMS = 40;

	// receiver stall behavior, re-rolled at the end of each random window
	typedef enum logic [1:0] {
		RX_OPEN,
		RX_RANDOM,
		RX_PERIODIC
	} rx_style_e;

	logic         clk = 1'b0;
	logic         arst_n = 1'b0;
	logic         item_valid = 1'b0;
	logic         item_stall;
	cdps_item_t   item = '0;
	logic         result_valid;
	logic         result_stall = 1'b0;
	cdps_result_t result;
	logic         cfg_valid = 1'b0;
	logic         cfg_ready;
	logic [1:0]   cfg_index = REG_LIMIT;
	logic [15:0]  cfg_data = '0;

	continuous_dp_spotting #(
		.REF_LEN(REF_LEN)
	) u_top (
		.clk         (clk),
		.arst_n      (arst_n),
		.item_valid  (item_valid),
		.item_stall  (item_stall),
		.item        (item),
		.result_valid(result_valid),
		.result_stall(result_stall),
		.result      (result),
		.cfg_valid   (cfg_valid),
		.cfg_ready   (cfg_ready),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data)
	);

	always #10 clk = ~clk;

	// ---------------------------------------------------------------------
	// Lattice predictor: own copy of the reference, the last two columns and
	// the registers. Columns hold values clipped at the limit in force when
	// they were computed, exactly as the block stores them.
	// ---------------------------------------------------------------------
	logic [7:0]  ref_mem     [REF_LEN];
	int unsigned prev_dist   [REF_LEN];
	int unsigned prev_acc    [REF_LEN];
	int unsigned prev2_acc   [REF_LEN];
	logic [16:0] prev_start  [REF_LEN];
	logic [16:0] prev2_start [REF_LEN];
	logic [15:0] frame_cnt;
	int unsigned cur_limit  = 32'(LIMIT_RESET);
	int unsigned cur_thresh = 32'(THRESH_RESET);

	cdps_result_t pending_spots[$];   // expected results, oldest first

	int unsigned fail_count = 0;
	int unsigned items_sent = 0;      // transactions the block acts on
	longint unsigned cycle_count = 0;

	function automatic int unsigned clamp_to_limit(int unsigned v);
		return (v >= cur_limit) ? cur_limit : v;
	endfunction

	// restart (and reset) empties both columns at the current limit
	function automatic void clear_lattice();
		for (int i = 0; i < REF_LEN; i++) begin
			prev_dist[i]   = 0;
			prev_acc[i]    = cur_limit;
			prev2_acc[i]   = cur_limit;
			prev_start[i]  = START_NONE;
			prev2_start[i] = START_NONE;
		end
		frame_cnt = '0;
	endfunction

	// apply one accepted transaction; a stream sample adds a column and queues
	// the last-row outcome
	function automatic void advance_lattice(cdps_item_t it);
		int unsigned  d_col   [REF_LEN];
		int unsigned  acc_col [REF_LEN];
		logic [16:0]  st_col  [REF_LEN];
		int unsigned  c1, c2, c3, r, dd, end_d;
		logic [16:0]  end_st;
		bit           found;
		cdps_result_t spot;

		case (it.action)
			ACT_LOAD: begin
				// indexes past the pattern are dropped
				if (it.ref_index < REF_LEN)
					ref_mem[it.ref_index] = it.sample;
			end
			ACT_RESTART: begin
				clear_lattice();
			end
			ACT_STREAM: begin
				for (int i = 0; i < REF_LEN; i++) begin
					r  = 32'(ref_mem[i]);
					dd = (r > it.sample) ? r - it.sample : it.sample - r;
					// rows 0..block_height are walled off; a height past the
					// last row blocks the whole column
					if (it.block_height != 0 && i <= it.block_height)
						dd = cur_limit;
					d_col[i] = clamp_to_limit(dd);
				end

				acc_col[0] = clamp_to_limit(3 * d_col[0]);
				st_col[0]  = {1'b0, frame_cnt};

				for (int i = 1; i < REF_LEN; i++) begin
					c1 = clamp_to_limit(prev2_acc[i-1] + 2 * prev_dist[i] + d_col[i]);
					c2 = clamp_to_limit(prev_acc[i-1] + 3 * d_col[i]);
					c3 = cur_limit;
					if (i >= 2)
						c3 = clamp_to_limit(prev_acc[i-2] + 3 * d_col[i-1] + 3 * d_col[i]);
					// tie order: slanted path, then straight, then double step
					if (c1 <= c2 && c1 <= c3 && c1 < cur_limit) begin
						acc_col[i] = c1;
						st_col[i]  = prev2_start[i-1];
					end else if (c2 <= c1 && c2 <= c3 && c2 < cur_limit) begin
						acc_col[i] = c2;
						st_col[i]  = prev_start[i-1];
					end else if (c3 <= c1 && c3 <= c2 && c3 < cur_limit) begin
						acc_col[i] = c3;
						st_col[i]  = prev_start[i-2];
					end else begin
						acc_col[i] = cur_limit;
						st_col[i]  = START_NONE;
					end
				end

				prev2_acc   = prev_acc;
				prev2_start = prev_start;
				prev_acc    = acc_col;
				prev_start  = st_col;
				prev_dist   = d_col;

				end_d  = acc_col[REF_LEN-1];
				end_st = st_col[REF_LEN-1];
				found  = (end_d < cur_limit) && !end_st[16];

				spot.frame_index     = frame_cnt;
				spot.end_distance    = end_d[15:0];
				spot.start_frame     = found ? end_st[15:0] : 16'd0;
				spot.path_found      = found;
				spot.below_threshold = found && (end_d < cur_thresh);
				pending_spots = {pending_spots, spot};

				frame_cnt = frame_cnt + 16'd1;
			end
			default: ; // unused action: no effect
		endcase
	endfunction

	// ---------------------------------------------------------------------
	// Result checker: every transaction on the result port is matched
	// against the oldest queued expectation.
	// ---------------------------------------------------------------------
	function automatic void check_field(string name, int unsigned want, int unsigned got);
		if (want != got) begin
			$error("%s: expected %0d, actual %0d", name, want, got);
			fail_count++;
		end
	endfunction

	always @(posedge clk) begin : check_spot
		cdps_result_t want;
		if (arst_n && result_valid && !result_stall) begin
			if (pending_spots.size() == 0) begin
				$error("result with no expectation: frame_index %0d", result.frame_index);
				fail_count++;
			end else begin
				want = pending_spots.pop_front();
				check_field("frame_index", 32'(want.frame_index),
					32'(result.frame_index));
				check_field("end_distance", 32'(want.end_distance),
					32'(result.end_distance));
				check_field("start_frame", 32'(want.start_frame),
					32'(result.start_frame));
				check_field("path_found", 32'(want.path_found),
					32'(result.path_found));
				check_field("below_threshold", 32'(want.below_threshold),
					32'(result.below_threshold));
			end
		end
	end

	// ---------------------------------------------------------------------
	// Receiver: stall style changes per window (open / random / periodic).
	// A hold-off request forces a long stall, counted here.
	// ---------------------------------------------------------------------
	rx_style_e   rx_style  = RX_OPEN;
	int unsigned rx_window = 0;
	int unsigned rx_phase  = 0;
	int unsigned rx_period = 8;
	int unsigned rx_duty   = 3;
	int unsigned hold_count = 0;
	bit          hold_req   = 1'b0;

	always @(negedge clk) begin
		if (hold_req) begin
			hold_count = HOLD_OFF;
			hold_req   = 1'b0;
		end
		if (rx_window == 0) begin
			rx_window = $urandom_range(20, 400);
			rx_style  = rx_style_e'($urandom_range(0, 2));
			rx_period = $urandom_range(2, 24);
			rx_duty   = $urandom_range(1, rx_period - 1);
			rx_phase  = 0;
		end
		rx_window--;
		rx_phase = (rx_phase + 1) % rx_period;
		if (hold_count != 0) begin
			hold_count--;
			result_stall <= 1'b1;
		end else begin
			case (rx_style)
				RX_OPEN:     result_stall <= 1'b0;
				RX_RANDOM:   result_stall <= ($urandom_range(0, 2) == 0);
				RX_PERIODIC: result_stall <= (rx_phase < rx_duty);
				default:     result_stall <= 1'b0;
			endcase
		end
	end

	// run-length guard
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("Some tests failed");
			$finish;
		end
	end

	// ---------------------------------------------------------------------
	// Sender: bursts of back-to-back transactions separated by random gaps.
	// Valid stays high across consecutive transactions inside a burst.
	// ---------------------------------------------------------------------
	int unsigned burst_left = 0;
	bit          pace_on    = 1'b1;

	task automatic send_item(cdps_item_t it);
		int unsigned gap;
		gap = 0;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 40);
			if (pace_on) begin
				case ($urandom_range(0, 9))
					0, 1, 2, 3, 4: gap = 0;
					5, 6, 7:       gap = $urandom_range(1, 5);
					default:       gap = $urandom_range(6, 120);
				endcase
			end
		end
		burst_left--;
		repeat (gap) begin
			@(negedge clk);
			item_valid <= 1'b0;
		end
		@(negedge clk);
		item_valid <= 1'b1;
		item       <= it;
		@(posedge clk);
		while (item_stall)
			@(posedge clk);
		advance_lattice(it);
		if (it.action != ACT_UNUSED)
			items_sent++;
	endtask

	function automatic cdps_item_t mk_item(logic [1:0] act, logic [7:0] s,
			logic [6:0] idx, logic [6:0] bh);
		cdps_item_t it;
		it.action       = act;
		it.sample       = s;
		it.ref_index    = idx;
		it.block_height = bh;
		return it;
	endfunction

	task automatic send_sample(logic [7:0] s, logic [6:0] bh);
		send_item(mk_item(ACT_STREAM, s, 7'($urandom), bh));
	endtask

	task automatic send_restart();
		send_item(mk_item(ACT_RESTART, 8'($urandom), 7'($urandom), 7'($urandom)));
	endtask

	// drop valid, wait for every expected result, then let a restart clearing
	// pass that has no result finish before anything touches the registers
	task automatic wait_idle();
		@(negedge clk);
		item_valid <= 1'b0;
		while (pending_spots.size() != 0)
			@(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic write_reg(logic [1:0] idx, logic [15:0] val);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		if (idx == REG_LIMIT)
			cur_limit = 32'(val);
		else if (idx == REG_THRESH)
			cur_thresh = 32'(val);
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	// play the stored pattern with a random time warp and small noise, the
	// shape a real occurrence has; occasionally a wall cuts through
	task automatic play_reference(int unsigned noise, bit walls);
		int          row;
		int          v;
		logic [6:0]  bh;
		row = 0;
		while (row < REF_LEN) begin
			v = int'(ref_mem[row]) + int'($urandom_range(0, 2 * noise)) - int'(noise);
			if (v < 0)
				v = 0;
			if (v > 255)
				v = 255;
			bh = 7'd0;
			if (walls && $urandom_range(0, 9) == 0)
				bh = 7'($urandom);
			send_sample(8'(v), bh);
			case ($urandom_range(0, 19))
				0, 1, 2:  row = row;        // dwell
				3, 4, 5:  row = row + 2;    // skip
				default:  row = row + 1;
			endcase
		end
	endtask

	// ---------------------------------------------------------------------
	// Tests
	// ---------------------------------------------------------------------

	// fill the whole pattern (never stream before that), plus dropped loads
	// past the end and the unused action
	task automatic test_load_reference();
		for (int i = 0; i < REF_LEN; i++) begin
			if (i == 0)
				send_item(mk_item(ACT_LOAD, 8'd0, 7'(i), 7'd0));
			else if (i == REF_LEN - 1)
				send_item(mk_item(ACT_LOAD, 8'd255, 7'(i), 7'd127));
			else
				send_item(mk_item(ACT_LOAD, 8'($urandom), 7'(i), 7'($urandom)));
		end
		send_item(mk_item(ACT_LOAD, 8'd255, 7'(REF_LEN), 7'd0));
		send_item(mk_item(ACT_LOAD, 8'd0, 7'd127, 7'd0));
		send_item(mk_item(ACT_UNUSED, 8'd255, 7'd127, 7'd127));
		wait_idle();
	endtask

	// sample extremes, wall heights at 1, last row and beyond, restart
	task automatic test_directed_stream();
		send_sample(8'd0, 7'd0);
		send_sample(8'd255, 7'd0);
		send_sample(ref_mem[0], 7'd0);
		send_sample(ref_mem[1], 7'd1);
		send_sample(8'd128, 7'(REF_LEN - 2));
		send_sample(8'd128, 7'(REF_LEN - 1));
		send_sample(8'd7, 7'd127);
		send_sample(ref_mem[2], 7'd0);
		send_sample(ref_mem[3], 7'd0);
		send_restart();
		send_sample(ref_mem[0], 7'd0);
		send_sample(ref_mem[1], 7'd0);
		send_item(mk_item(ACT_UNUSED, 8'd0, 7'd0, 7'd0));
		send_sample(ref_mem[2], 7'd0);
		wait_idle();
	endtask

	// register extremes, each followed by a clean occurrence of the pattern
	task automatic test_register_extremes();
		logic [15:0] lims [5];
		logic [15:0] ths  [5];
		lims = '{16'd65535, 16'd1, 16'd0, 16'd600, LIMIT_RESET};
		ths  = '{16'd65535, 16'd0, 16'd65535, 16'd400, 16'd1000};
		for (int k = 0; k < 5; k++) begin
			write_reg(REG_LIMIT, lims[k]);
			write_reg(REG_THRESH, ths[k]);
			send_restart();
			play_reference(0, 1'b0);
			send_sample(8'($urandom), 7'd0);
			wait_idle();
		end
	endtask

	// change the limit under live columns: values clipped at an older limit
	// are then compared with the new one
	task automatic test_limit_change();
		write_reg(REG_LIMIT, 16'd65535);
		write_reg(REG_THRESH, 16'd30000);
		send_restart();
		play_reference(2, 1'b0);
		wait_idle();
		write_reg(REG_LIMIT, 16'd300);
		play_reference(1, 1'b0);
		wait_idle();
		write_reg(REG_LIMIT, 16'd60000);
		play_reference(1, 1'b0);
		wait_idle();
		write_reg(REG_LIMIT, 16'd0);
		play_reference(0, 1'b0);
		wait_idle();
		write_reg(REG_LIMIT, 16'd5000);
		play_reference(0, 1'b0);
		wait_idle();
	endtask

	// receiver stops for a long stretch while the sender keeps offering, so
	// the block fills and stalls its input
	task automatic test_output_backpressure();
		pace_on  = 1'b0;
		hold_req = 1'b1;
		for (int k = 0; k < 40; k++)
			send_sample(8'($urandom), 7'd0);
		pace_on = 1'b1;
		wait_idle();
	endtask

	// phases of random registers; mostly warped, noisy occurrences of the
	// pattern, with noise runs, walls, reloads, restarts in between
	task automatic test_random_phases();
		int unsigned target;
		int unsigned lim;
		int unsigned len;
		for (int p = 0; p < 7; p++) begin
			case ($urandom_range(0, 4))
				0:       lim = 65535;
				1:       lim = $urandom_range(1, 2000);
				default: lim = $urandom_range(2000, 65535);
			endcase
			write_reg(REG_LIMIT, 16'(lim));
			if ($urandom_range(0, 3) == 0)
				write_reg(REG_THRESH, 16'($urandom));
			else
				write_reg(REG_THRESH, 16'($urandom_range(0, lim)));
			if ($urandom_range(0, 3) != 0)
				send_restart();
			target = items_sent + PHASE_ITEMS;
			while (items_sent < target) begin
				case ($urandom_range(0, 19))
					0, 1, 2: begin
						len = $urandom_range(1, 20);
						repeat (len) send_sample(8'($urandom), 7'd0);
					end
					3: begin
						len = $urandom_range(1, 6);
						repeat (len) send_sample(8'($urandom), 7'($urandom));
					end
					4, 5: begin
						len = $urandom_range(1, 4);
						repeat (len)
							send_item(mk_item(ACT_LOAD, 8'($urandom), 7'($urandom),
								7'($urandom)));
					end
					6:       send_restart();
					7:       send_item(mk_item(ACT_UNUSED, 8'($urandom), 7'($urandom),
							7'($urandom)));
					default: play_reference($urandom_range(0, 4), 1'b1);
				endcase
			end
			wait_idle();
		end
	endtask

	initial begin
		clear_lattice();
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		// block runs a clearing sweep after reset; settle before any write
		wait_idle();

		test_load_reference();
		test_directed_stream();
		test_register_extremes();
		test_limit_change();
		test_output_backpressure();
		test_random_phases();

		wait_idle();
		if (fail_count == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule
